/* rtl/core/ws2812_pkg.sv */
// shared types, register codes and reset values for the led pulse serializer
package ws2812_pkg;

  localparam int unsigned TickW        = 16;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned BitsPerColor = 8;
  localparam int unsigned NumColorsDef = 3;
  localparam int unsigned CfgAddrW     = 3;

  typedef enum logic [CfgAddrW-1:0] {
    REG_ZERO_HIGH  = 3'd0,
    REG_ONE_HIGH   = 3'd1,
    REG_ZERO_LOW   = 3'd2,
    REG_ONE_LOW    = 3'd3,
    REG_LATCH_HIGH = 3'd4,
    REG_LATCH_LOW  = 3'd5
  } cfg_reg_e;

  localparam logic [TickW-1:0] ZeroHighRst  = 16'd2;
  localparam logic [TickW-1:0] OneHighRst   = 16'd7;
  localparam logic [TickW-1:0] ZeroLowRst   = 16'd49;
  localparam logic [TickW-1:0] OneLowRst    = 16'd49;
  localparam logic [TickW-1:0] LatchHighRst = 16'd7;
  localparam logic [TickW-1:0] LatchLowRst  = 16'd100;

  typedef struct packed {
    logic [TickW-1:0] zero_high;
    logic [TickW-1:0] one_high;
    logic [TickW-1:0] zero_low;
    logic [TickW-1:0] one_low;
    logic [TickW-1:0] latch_high;
    logic [TickW-1:0] latch_low;
  } cfg_t;

  // what kind of pulse the sequencer asks for
  typedef struct packed {
    logic bit_value;
    logic is_latch;
  } pulse_req_t;

  typedef struct packed {
    logic [TickW-1:0] high_ticks;
    logic [TickW-1:0] low_ticks;
  } pulse_ticks_t;

endpackage

/* rtl/core/ws2812_cfg_regs.sv */
// timing register file written over the configuration channel
module ws2812_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ws2812_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [ws2812_pkg::TickW-1:0]  cfg_data_i,
  output ws2812_pkg::cfg_t              cfg_o
);
  import ws2812_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_high  <= ZeroHighRst;
      cfg_q.one_high   <= OneHighRst;
      cfg_q.zero_low   <= ZeroLowRst;
      cfg_q.one_low    <= OneLowRst;
      cfg_q.latch_high <= LatchHighRst;
      cfg_q.latch_low  <= LatchLowRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_ZERO_HIGH:  cfg_q.zero_high  <= cfg_data_i;
        REG_ONE_HIGH:   cfg_q.one_high   <= cfg_data_i;
        REG_ZERO_LOW:   cfg_q.zero_low   <= cfg_data_i;
        REG_ONE_LOW:    cfg_q.one_low    <= cfg_data_i;
        REG_LATCH_HIGH: cfg_q.latch_high <= cfg_data_i;
        REG_LATCH_LOW:  cfg_q.latch_low  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/ws2812_pulse_sel.sv */
// shared pulse timing selector, used once per emitted record
module ws2812_pulse_sel (
  input  ws2812_pkg::cfg_t         cfg_i,
  input  ws2812_pkg::pulse_req_t   req_i,
  output ws2812_pkg::pulse_ticks_t ticks_o
);
  import ws2812_pkg::*;

  always_comb begin
    if (req_i.is_latch) begin
      ticks_o.high_ticks = cfg_i.latch_high;
      ticks_o.low_ticks  = cfg_i.latch_low;
    end else if (req_i.bit_value) begin
      ticks_o.high_ticks = cfg_i.one_high;
      ticks_o.low_ticks  = cfg_i.one_low;
    end else begin
      ticks_o.high_ticks = cfg_i.zero_high;
      ticks_o.low_ticks  = cfg_i.zero_low;
    end
  end

endmodule

/* rtl/core/ws2812_seq.sv */
// bit sequencer: shift register, record counter and output register
module ws2812_seq #(
  parameter int unsigned NumColors = ws2812_pkg::NumColorsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [ws2812_pkg::ByteW-1:0]   red_i,
  input  logic [ws2812_pkg::ByteW-1:0]   green_i,
  input  logic [ws2812_pkg::ByteW-1:0]   blue_i,
  output ws2812_pkg::pulse_req_t         req_o,
  input  ws2812_pkg::pulse_ticks_t       ticks_i,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output ws2812_pkg::pulse_ticks_t       m_ticks_o,
  output logic                           m_bit_o,
  output logic                           m_latch_o
);
  import ws2812_pkg::*;

  localparam int unsigned NumBits = NumColors * BitsPerColor;
  localparam int unsigned CntW    = $clog2(NumBits + 1);
  localparam logic [CntW-1:0] LatchCnt = CntW'(NumBits);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e             state_q;
  logic [NumBits-1:0] sreg_q;
  logic [CntW-1:0]    cnt_q;
  logic               m_valid_q;
  pulse_ticks_t       m_ticks_q;
  logic               m_bit_q;
  logic               m_latch_q;

  logic [4*ByteW-1:0] load_full;
  logic               emit;
  logic               at_latch;

  // grb order, an optional fourth byte goes out as zero
  assign load_full = {green_i, red_i, blue_i, {ByteW{1'b0}}};

  assign at_latch       = (cnt_q == LatchCnt);
  assign emit           = (state_q == ST_RUN) && (!m_valid_q || m_ready_i);
  assign req_o.is_latch = at_latch;
  assign req_o.bit_value = !at_latch && sreg_q[NumBits-1];

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;
  assign m_ticks_o = m_ticks_q;
  assign m_bit_o   = m_bit_q;
  assign m_latch_o = m_latch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sreg_q    <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      m_ticks_q <= '0;
      m_bit_q   <= 1'b0;
      m_latch_q <= 1'b0;
    end else begin
      if (m_valid_q && m_ready_i && !emit) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_valid_i) begin
            sreg_q  <= load_full[4*ByteW-1 -: NumBits];
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit) begin
            m_valid_q <= 1'b1;
            m_ticks_q <= ticks_i;
            m_bit_q   <= req_o.bit_value;
            m_latch_q <= at_latch;
            if (at_latch) begin
              cnt_q   <= '0;
              state_q <= ST_IDLE;
            end else begin
              sreg_q <= {sreg_q[NumBits-2:0], 1'b0};
              cnt_q  <= cnt_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LatchCnt)
    else $error("record counter past latch position");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_i && s_ready_o |=> state_q == ST_RUN && cnt_q == '0)
    else $error("new item did not start at record zero");

  a_latch_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && at_latch |=> state_q == ST_IDLE && m_latch_q && !m_bit_q)
    else $error("latch record did not end the item");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> cnt_q == '0)
    else $error("counter not cleared while idle");

endmodule

/* rtl/core/ws2812_pulse_serializer.sv */
// top level: one rgb color in, NUM_COLORS*8+1 pulse records out, one per cycle while the sink is ready
// the first record is registered from the run state that the accepted item enters
// no new color is taken until the latch record of the last one has been emitted;
//   the bit sequencer emits one record a cycle, while the sink is ready, through the shared timing selector
// reset: rst_ni async active low; idle, output empty, timing registers at defaults
module ws2812_pulse_serializer #(
  parameter int unsigned NUM_COLORS = ws2812_pkg::NumColorsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // high_ticks[15:0], low_ticks[31:16], bit_value[32], pad
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // is_latch[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [ws2812_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [ws2812_pkg::TickW-1:0]    cfg_data_i
);
  import ws2812_pkg::*;

  cfg_t         cfg;
  pulse_req_t   req;
  pulse_ticks_t ticks;
  pulse_ticks_t m_ticks;
  logic         m_bit;
  logic         m_latch;

  ws2812_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ws2812_pulse_sel u_sel (
    .cfg_i  (cfg),
    .req_i  (req),
    .ticks_o(ticks)
  );

  ws2812_seq #(
    .NumColors(NUM_COLORS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .red_i    (s_axis_tdata[7:0]),
    .green_i  (s_axis_tdata[15:8]),
    .blue_i   (s_axis_tdata[23:16]),
    .req_o    (req),
    .ticks_i  (ticks),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_ticks_o(m_ticks),
    .m_bit_o  (m_bit),
    .m_latch_o(m_latch)
  );

  assign m_axis_tdata = {7'b0, m_bit, m_ticks.low_ticks, m_ticks.high_ticks};
  assign m_axis_tlast = m_latch;
  assign m_axis_tuser = m_latch;

endmodule
